// ----- rtl/transformed_aabb_and_overlap_defines.svh -----
// Assertion macros used by the controller RTL file of the box unit.
`ifndef TRANSFORMED_AABB_AND_OVERLAP_DEFINES_SVH
`define TRANSFORMED_AABB_AND_OVERLAP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define TAO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TAO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tao_pkg.sv -----
`default_nettype none

package tao_pkg;

  // Field widths
  localparam int CoordW = 32;
  localparam int HalfW  = 31;
  localparam int CfgW   = 64;
  localparam int CfgIdxW = 3;
  localparam int ProdW  = 48;
  localparam int AccW   = 50;

  // Register reset values: identity rotation, unit scale, zero position
  localparam logic [47:0] RotRow0Rst  = 48'h0000_0000_4000;
  localparam logic [47:0] RotRow1Rst  = 48'h0000_4000_0000;
  localparam logic [47:0] RotRow2Rst  = 48'h4000_0000_0000;
  localparam logic [47:0] ScaleXyzRst = 48'h0100_0100_0100;
  localparam logic [HalfW-1:0] HalfRst = 31'd256;

  localparam logic signed [CoordW-1:0] Int32Max = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] Int32Min = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_ROW0 = 3'd0,
    CFG_ROT_ROW1 = 3'd1,
    CFG_ROT_ROW2 = 3'd2,
    CFG_SCALE    = 3'd3,
    CFG_POS_XY   = 3'd4,
    CFG_POS_Z    = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_BOX   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_MUL,
    ST_ROT_ACC,
    ST_SAT,
    ST_SCL_MUL,
    ST_POS,
    ST_UPD,
    ST_FIN_HALF,
    ST_FIN_CTR,
    ST_QRY_DIST,
    ST_QRY_CMP
  } ctrl_state_e;

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [HalfW-1:0]         other_half_x;
    logic [HalfW-1:0]         other_half_y;
    logic [HalfW-1:0]         other_half_z;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [HalfW-1:0]         half_x;
    logic [HalfW-1:0]         half_y;
    logic [HalfW-1:0]         half_z;
    logic                     contact;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic       mul_scale;
    logic       acc_en;
    logic       acc_clr;
    logic       sat_en;
    logic       pos_en;
    logic       upd_en;
    logic       fin_half;
    logic       fin_ctr;
    logic       qry_dist;
    logic       qry_cmp;
    logic [1:0] axis;
    logic [1:0] col;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/transformed_aabb_and_overlap.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | in_i (op, coord, other_half, last)
// out     | output    | out_valid_o/out_ready_i | out_o (kind, center, half, contact)
// cfg     | input     | cfg_we_i (no wait)   | cfg_idx_i, cfg_data_i
//
// A vertex runs rotation, saturate, scale, offset and update per axis, plus finish
// steps when it closes a mesh; a query runs distance and compare. The single shared
// 32x17 multiplier serves four uses per axis (three rotation terms and one scale term).
// Reset (asynchronous, active low) restores identity transform and the unit box.
// A finished result waits in the output register; only a second result stalls.

`default_nettype none

module transformed_aabb_and_overlap (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tao_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tao_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  tao_pkg::in_item_t                in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tao_pkg::out_item_t               out_o
);

  tao_pkg::dp_cmd_t    cmd;
  tao_pkg::dp_status_t st;

  tao_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.op),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .st_i       (st)
  );

  tao_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tao_dp.sv -----
`default_nettype none

module tao_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tao_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tao_pkg::CfgW-1:0]      cfg_data_i,
  input  tao_pkg::in_item_t                  in_i,
  input  tao_pkg::dp_cmd_t                   cmd_i,
  output tao_pkg::dp_status_t                st_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output tao_pkg::out_item_t                 out_o
);

  localparam int CW = tao_pkg::CoordW;
  localparam int HW = tao_pkg::HalfW;
  localparam int PW = tao_pkg::ProdW;
  localparam int AW = tao_pkg::AccW;

  // Configuration registers
  logic [47:0]   rot_row0_q, rot_row1_q, rot_row2_q, scale_xyz_q;
  logic [63:0]   position_xy_q;
  logic [CW-1:0] position_z_q;

  // Captured item and arithmetic registers
  tao_pkg::in_item_t      in_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [CW-1:0]   r_q;
  logic signed [CW-1:0]   p_q;

  // Per-axis box state
  logic signed [CW-1:0]   min_q [3];
  logic signed [CW-1:0]   max_q [3];
  logic signed [CW-1:0]   ctr_q [3];
  logic [HW-1:0]          half_q [3];
  logic [CW-1:0]          dist_q [3];
  logic [CW-1:0]          lim_q [3];
  logic                   first_q;

  tao_pkg::out_item_t     out_q;
  logic                   out_valid_q;

  // Operand selection
  logic [47:0]            row_sel;
  logic [15:0]            rot_ent;
  logic signed [CW-1:0]   coord_sel;
  logic [15:0]            scale_sel;
  logic signed [CW-1:0]   pos_sel;
  logic signed [CW-1:0]   mul_a;
  logic signed [16:0]     mul_b;
  logic signed [PW:0]     prod_full;
  logic signed [AW-1:0]   acc_base;
  logic signed [AW-1:0]   acc_add;
  logic signed [CW-1:0]   sat_r;
  logic signed [40:0]     pos_sum;
  logic signed [CW-1:0]   sat_p;
  logic signed [CW-1:0]   c_lane [3];
  logic [HW-1:0]          oh_lane [3];
  logic signed [CW-1:0]   ctr_d [3];
  logic [2:0]             ok;
  tao_pkg::out_item_t     out_d;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_row0_q    <= tao_pkg::RotRow0Rst;
      rot_row1_q    <= tao_pkg::RotRow1Rst;
      rot_row2_q    <= tao_pkg::RotRow2Rst;
      scale_xyz_q   <= tao_pkg::ScaleXyzRst;
      position_xy_q <= '0;
      position_z_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tao_pkg::CFG_ROT_ROW0: rot_row0_q    <= cfg_data_i[47:0];
        tao_pkg::CFG_ROT_ROW1: rot_row1_q    <= cfg_data_i[47:0];
        tao_pkg::CFG_ROT_ROW2: rot_row2_q    <= cfg_data_i[47:0];
        tao_pkg::CFG_SCALE:    scale_xyz_q   <= cfg_data_i[47:0];
        tao_pkg::CFG_POS_XY:   position_xy_q <= cfg_data_i;
        tao_pkg::CFG_POS_Z:    position_z_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Pick rotation entry, coordinate, scale and offset for the current step
  always_comb begin
    case (cmd_i.axis)
      2'd1:    row_sel = rot_row1_q;
      2'd2:    row_sel = rot_row2_q;
      default: row_sel = rot_row0_q;
    endcase
    case (cmd_i.col)
      2'd1:    begin rot_ent = row_sel[31:16]; coord_sel = in_q.coord_y; end
      2'd2:    begin rot_ent = row_sel[47:32]; coord_sel = in_q.coord_z; end
      default: begin rot_ent = row_sel[15:0];  coord_sel = in_q.coord_x; end
    endcase
    case (cmd_i.axis)
      2'd1:    begin scale_sel = scale_xyz_q[31:16]; pos_sel = position_xy_q[63:32]; end
      2'd2:    begin scale_sel = scale_xyz_q[47:32]; pos_sel = position_z_q; end
      default: begin scale_sel = scale_xyz_q[15:0];  pos_sel = position_xy_q[31:0]; end
    endcase
  end

  // Shared 32x17 multiplier for rotation and scale products
  assign mul_a     = cmd_i.mul_scale ? r_q : coord_sel;
  assign mul_b     = cmd_i.mul_scale ? $signed({1'b0, scale_sel})
                                     : $signed({rot_ent[15], rot_ent});
  assign prod_full = mul_a * mul_b;

  assign acc_base = cmd_i.acc_clr ? '0 : acc_q;
  assign acc_add  = $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});

  // Saturate the row sum after the Q2.14 shift
  always_comb begin
    if ((&acc_q[AW-1:45]) || !(|acc_q[AW-1:45])) begin
      sat_r = acc_q[45:14];
    end else begin
      sat_r = acc_q[AW-1] ? tao_pkg::Int32Min : tao_pkg::Int32Max;
    end
  end

  // Drop Q8.8 fraction, add offset, saturate
  assign pos_sum = $signed({prod_q[PW-1], prod_q[PW-1:8]})
                 + $signed({pos_sel[CW-1], pos_sel});
  always_comb begin
    if ((&pos_sum[40:31]) || !(|pos_sum[40:31])) begin
      sat_p = pos_sum[CW-1:0];
    end else begin
      sat_p = pos_sum[40] ? tao_pkg::Int32Min : tao_pkg::Int32Max;
    end
  end

  // Capture item and advance the arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_full[PW-1:0];
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_base + acc_add;
    end
    if (cmd_i.sat_en) begin
      r_q <= sat_r;
    end
    if (cmd_i.pos_en) begin
      p_q <= sat_p;
    end
  end

  assign c_lane[0]  = in_q.coord_x;
  assign c_lane[1]  = in_q.coord_y;
  assign c_lane[2]  = in_q.coord_z;
  assign oh_lane[0] = in_q.other_half_x;
  assign oh_lane[1] = in_q.other_half_y;
  assign oh_lane[2] = in_q.other_half_z;

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [CW:0] span;
    logic               ge;
    logic [CW:0]        diff;

    assign span     = $signed({max_q[k][CW-1], max_q[k]}) - $signed({min_q[k][CW-1], min_q[k]});
    assign ctr_d[k] = max_q[k] - $signed({1'b0, half_q[k]});
    assign ge       = ctr_q[k] >= c_lane[k];
    assign diff     = ge ? ({ctr_q[k][CW-1], ctr_q[k]} - {c_lane[k][CW-1], c_lane[k]})
                         : ({c_lane[k][CW-1], c_lane[k]} - {ctr_q[k][CW-1], ctr_q[k]});
    assign ok[k]    = dist_q[k] <= lim_q[k];

    // Track extent, then finish half-size and center
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        min_q[k]  <= '0;
        max_q[k]  <= '0;
        ctr_q[k]  <= '0;
        half_q[k] <= tao_pkg::HalfRst;
      end else begin
        if (cmd_i.upd_en && (cmd_i.axis == 2'(k))) begin
          if (first_q || (p_q < min_q[k])) begin
            min_q[k] <= p_q;
          end
          if (first_q || (p_q > max_q[k])) begin
            max_q[k] <= p_q;
          end
        end
        if (cmd_i.fin_half) begin
          half_q[k] <= span[HW:1];
        end
        if (cmd_i.fin_ctr) begin
          ctr_q[k] <= ctr_d[k];
        end
      end
    end

    // Hold query distance and allowed gap
    always_ff @(posedge clk_i) begin
      if (cmd_i.qry_dist) begin
        dist_q[k] <= diff[CW-1:0];
        lim_q[k]  <= {1'b0, half_q[k]} + {1'b0, oh_lane[k]};
      end
    end
  end

  // First vertex of a mesh loads both corners
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (cmd_i.fin_ctr) begin
      first_q <= 1'b1;
    end else if (cmd_i.upd_en && (cmd_i.axis == 2'd2)) begin
      first_q <= 1'b0;
    end
  end

  // Build the result item
  always_comb begin
    out_d = '0;
    if (cmd_i.fin_ctr) begin
      out_d.kind     = tao_pkg::KIND_BOX;
      out_d.center_x = ctr_d[0];
      out_d.center_y = ctr_d[1];
      out_d.center_z = ctr_d[2];
      out_d.half_x   = half_q[0];
      out_d.half_y   = half_q[1];
      out_d.half_z   = half_q[2];
    end else begin
      out_d.kind    = tao_pkg::KIND_QUERY;
      out_d.contact = &ok;
    end
  end

  // Output register: load a result, drop it after its transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_ctr || cmd_i.qry_cmp) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_ctr || cmd_i.qry_cmp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;
  assign st_o.is_last    = in_q.last;
  assign st_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

// ----- rtl/tao_ctrl.sv -----
`default_nettype none

`include "transformed_aabb_and_overlap_defines.svh"

module tao_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_op_i,
  output logic                in_ready_o,
  output tao_pkg::dp_cmd_t    cmd_o,
  input  tao_pkg::dp_status_t st_i
);

  tao_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]           axis_q, axis_d;
  logic [1:0]           col_q, col_d;

  // State and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tao_pkg::ST_IDLE;
      axis_q  <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      col_q   <= col_d;
    end
  end

  // Sequence: three rotation products per axis, saturate, scale, offset, update; finish a mesh or run a query
  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    col_d      = col_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    cmd_o.col  = col_q;
    case (state_q)
      tao_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        axis_d        = '0;
        col_d         = '0;
        if (in_valid_i) begin
          state_d = (in_op_i == tao_pkg::OP_QUERY) ? tao_pkg::ST_QRY_DIST
                                                   : tao_pkg::ST_ROT_MUL;
        end
      end
      tao_pkg::ST_ROT_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = tao_pkg::ST_ROT_ACC;
      end
      tao_pkg::ST_ROT_ACC: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_clr = (col_q == 2'd0);
        if (col_q == 2'd2) begin
          col_d   = '0;
          state_d = tao_pkg::ST_SAT;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = tao_pkg::ST_ROT_MUL;
        end
      end
      tao_pkg::ST_SAT: begin
        cmd_o.sat_en = 1'b1;
        state_d      = tao_pkg::ST_SCL_MUL;
      end
      tao_pkg::ST_SCL_MUL: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_scale = 1'b1;
        state_d         = tao_pkg::ST_POS;
      end
      tao_pkg::ST_POS: begin
        cmd_o.pos_en = 1'b1;
        state_d      = tao_pkg::ST_UPD;
      end
      tao_pkg::ST_UPD: begin
        cmd_o.upd_en = 1'b1;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = st_i.is_last ? tao_pkg::ST_FIN_HALF : tao_pkg::ST_IDLE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = tao_pkg::ST_ROT_MUL;
        end
      end
      tao_pkg::ST_FIN_HALF: begin
        cmd_o.fin_half = 1'b1;
        state_d        = tao_pkg::ST_FIN_CTR;
      end
      tao_pkg::ST_FIN_CTR: begin
        // Hold until the output register is free
        if (!st_i.out_busy) begin
          cmd_o.fin_ctr = 1'b1;
          state_d       = tao_pkg::ST_IDLE;
        end
      end
      tao_pkg::ST_QRY_DIST: begin
        cmd_o.qry_dist = 1'b1;
        state_d        = tao_pkg::ST_QRY_CMP;
      end
      tao_pkg::ST_QRY_CMP: begin
        if (!st_i.out_busy) begin
          cmd_o.qry_cmp = 1'b1;
          state_d       = tao_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tao_pkg::ST_IDLE;
      end
    endcase
  end

  `TAO_ASSERT_IMP(a_no_load_busy, clk_i, rst_ni, cmd_o.fin_ctr || cmd_o.qry_cmp, !st_i.out_busy, "result loaded over an untaken result")
  `TAO_ASSERT_IMP(a_ready_quiet, clk_i, rst_ni, in_ready_o, !(cmd_o.mul_en || cmd_o.acc_en || cmd_o.upd_en || cmd_o.fin_half || cmd_o.qry_dist), "datapath busy while ready")
  `TAO_ASSERT_IMP(a_step_range, clk_i, rst_ni, 1'b1, (axis_q != 2'd3) && (col_q != 2'd3), "axis or column counter out of range")
  `TAO_ASSERT_NXT(a_plain_vertex_done, clk_i, rst_ni, cmd_o.upd_en && (axis_q == 2'd2) && !st_i.is_last, in_ready_o, "plain vertex did not return to ready")

endmodule

`default_nettype wire
